// ----- sv/urbq_pkg.sv -----
package urbq_pkg;

	localparam int TX_DEPTH = 512;
	localparam int RX_DEPTH = 1024;
	localparam int TX_AW    = $clog2(TX_DEPTH);
	localparam int RX_AW    = $clog2(RX_DEPTH);

	localparam logic [1:0] REQ_PUT  = 2'd0;
	localparam logic [1:0] REQ_DONE = 2'd1;
	localparam logic [1:0] REQ_RX   = 2'd2;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_PUT  = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
	} urbq_in_t;

	typedef struct packed {
		logic [1:0] put_status;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       transmitter_busy;
		logic       queue_full;
		logic [9:0] rx_position;
	} urbq_out_t;

	function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] i);
		return (i == TX_AW'(TX_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] i);
		return (i == RX_AW'(RX_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

// ----- sv/urbq_ram.sv -----
module urbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- sv/uart_ring_buffer_queue_core.sv -----
// Serial transmit/receive queue.
// Input channel (in_valid/in_ready/in_item) carries one request per transfer:
// put a byte for sending, a transmit-done event, or a received byte.
// Output channel (out_valid/out_ready/out_item) returns exactly one result per
// request, in request order.
// The result is registered and shows in the cycle after the input transfer;
// a transmit-done that sends a queued byte first waits in a read state for
// the byte from the single port of the transmit ring memory.
// Throughput: one request per cycle while the receiver takes each result,
// but the input is held off while a queued byte is read (read state).
// Reset clears the read/write indices and the full and active flags; the ring
// memories are not cleared and need no clearing pass.
// When the receiver stalls, the result stays in the output register and the
// next request is taken only in the cycle that result is transferred.
module uart_ring_buffer_queue_core
	import urbq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  urbq_in_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output urbq_out_t out_item
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic             state_q;
	logic             out_valid_q;
	urbq_out_t        out_q;
	logic [TX_AW-1:0] tx_rd_q, tx_wr_q;
	logic [RX_AW-1:0] rx_wr_q;
	logic             full_q, active_q;

	logic             accept;
	logic             go_read;
	logic             tx_we, rx_we;
	logic [TX_AW-1:0] tx_addr;
	logic [7:0]       tx_rdata;
	logic [TX_AW-1:0] tx_rd_d, tx_wr_d;
	logic [RX_AW-1:0] rx_wr_d;
	logic             full_d, active_d;
	urbq_out_t        res;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		tx_rd_d  = tx_rd_q;
		tx_wr_d  = tx_wr_q;
		rx_wr_d  = rx_wr_q;
		full_d   = full_q;
		active_d = active_q;
		tx_we    = 1'b0;
		rx_we    = 1'b0;
		go_read  = 1'b0;
		tx_addr  = tx_wr_q;
		res      = '0;
		res.put_status = ST_NOT_PUT;
		case (in_item.req_type)
			REQ_PUT: begin
				if (full_q) begin
					res.put_status = ST_FULL;
				end else if (!active_q) begin
					active_d       = 1'b1;
					res.send_valid = 1'b1;
					res.send_byte  = in_item.data_byte;
					res.put_status = ST_ACCEPTED;
				end else begin
					// write the slot even when refused; the index does not advance
					tx_we = 1'b1;
					if (tx_next(tx_wr_q) == tx_rd_q) begin
						full_d         = 1'b1;
						res.put_status = ST_FULL;
					end else begin
						tx_wr_d        = tx_next(tx_wr_q);
						full_d         = 1'b0;
						res.put_status = ST_ACCEPTED;
					end
				end
			end
			REQ_DONE: begin
				if (tx_rd_q != tx_wr_q) begin
					tx_addr = tx_rd_q;
					go_read = 1'b1;
					tx_rd_d = tx_next(tx_rd_q);
					full_d  = 1'b0;
				end else begin
					active_d = 1'b0;
				end
			end
			REQ_RX: begin
				rx_we   = 1'b1;
				rx_wr_d = rx_next(rx_wr_q);
			end
			default: begin
			end
		endcase
		res.transmitter_busy = active_d;
		res.queue_full       = full_d;
		res.rx_position      = 10'(rx_wr_d);
	end

	urbq_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (accept && tx_we),
		.addr  (tx_addr),
		.wdata (in_item.data_byte),
		.rdata (tx_rdata)
	);

	urbq_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (accept && rx_we),
		.addr  (rx_wr_q),
		.wdata (in_item.data_byte),
		.rdata ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			tx_rd_q     <= '0;
			tx_wr_q     <= '0;
			rx_wr_q     <= '0;
			full_q      <= 1'b0;
			active_q    <= 1'b0;
		end else begin
			if (accept) begin
				tx_rd_q  <= tx_rd_d;
				tx_wr_q  <= tx_wr_d;
				rx_wr_q  <= rx_wr_d;
				full_q   <= full_d;
				active_q <= active_d;
				if (go_read) begin
					state_q     <= S_READ;
					out_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (state_q == S_READ) begin
				state_q     <= S_IDLE;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !go_read) begin
			out_q <= res;
		end else if (state_q == S_READ) begin
			// flags and indices already hold their post-step values
			out_q.put_status       <= ST_NOT_PUT;
			out_q.send_valid       <= 1'b1;
			out_q.send_byte        <= tx_rdata;
			out_q.transmitter_busy <= active_q;
			out_q.queue_full       <= full_q;
			out_q.rx_position      <= 10'(rx_wr_q);
		end
	end

	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !in_ready)
		else $error("request taken while ring read pending");

	a_read_gives_send: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (out_valid_q && out_q.send_valid && state_q == S_IDLE))
		else $error("ring read did not produce a send result");

	a_full_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> active_q)
		else $error("ring full while transmitter idle");

	a_full_indices: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (tx_next(tx_wr_q) == tx_rd_q))
		else $error("full flag disagrees with ring indices");

endmodule
